// ===== hdl/mmn12_pkg.sv =====
// Package for the min-max normaliser: sizes, state encoding and datapath constants.
`timescale 1ns / 1ps

package mmn12_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);

    localparam int SAMPLE_W    = 32;
    localparam int LEVEL_W     = 12;
    localparam int OUT_DATA_W  = 16;
    localparam int NUM_W       = SAMPLE_W + LEVEL_W;
    localparam int STEP_W      = 4;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LEVEL_W - 1);

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_READ = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

// ===== hdl/min_max_normalize_12bit.sv =====
// Min-max normaliser: stores a set of samples, then emits each scaled to 12 bits.
// Loading takes one cycle per sample word; the set is emitted after the word marked last
// or the word that fills the 64-entry store.
// Each result passes through store read, subtract and times-4095 prep, the 12-bit restoring
// divider producing one quotient bit per cycle, then the output state until the word is taken.
// A flat set (max equal to min) skips the divider.
// Reset clears count, running min/max and state; store contents stay undefined until written.
`timescale 1ns / 1ps

module min_max_normalize_12bit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mmn12_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [31:0] sample
    input  logic                              s_axis_tlast,   // last_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mmn12_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [11:0] level, [15:12] zero
    output logic                              m_axis_tlast    // last_out
);

    import mmn12_pkg::*;

    logic [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] range_reg, range_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [LEVEL_W-1:0]  numlo_reg, numlo_next;
    logic [LEVEL_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic                in_accept;
    logic                out_accept;
    logic                set_done;
    logic                last_word;
    logic [SAMPLE_W-1:0] diff;
    logic [NUM_W-1:0]    num;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   trial_sub;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign set_done   = s_axis_tlast || (count_reg == COUNT_W'(MAX_SAMPLES - 1));
    assign last_word  = ({1'b0, idx_reg} + COUNT_W'(1)) == count_reg;

    // x*4095 as (x << 12) - x
    assign diff      = rd_data_reg - min_reg;
    assign num       = {diff, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, diff};
    assign trial     = {rem_reg, numlo_reg[LEVEL_W-1]};
    assign trial_sub = trial - {1'b0, range_reg};

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {{(OUT_DATA_W - LEVEL_W){1'b0}}, quot_reg};
    assign m_axis_tlast  = last_word;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= s_axis_tdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        idx_next   = idx_reg;
        range_next = range_reg;
        rem_next   = rem_reg;
        numlo_next = numlo_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    count_next = count_reg + COUNT_W'(1);
                    if (s_axis_tdata < min_reg)
                    begin
                        min_next = s_axis_tdata;
                    end
                    if (s_axis_tdata > max_reg)
                    begin
                        max_next = s_axis_tdata;
                    end
                    if (set_done)
                    begin
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                range_next = max_reg - min_reg;
                rem_next   = num[NUM_W-1:LEVEL_W];
                numlo_next = num[LEVEL_W-1:0];
                quot_next  = '0;
                step_next  = '0;
                // flat set: every level is zero
                if (max_reg <= min_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!trial_sub[SAMPLE_W])
                begin
                    rem_next  = trial_sub[SAMPLE_W-1:0];
                    quot_next = {quot_reg[LEVEL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[SAMPLE_W-1:0];
                    quot_next = {quot_reg[LEVEL_W-2:0], 1'b0};
                end
                numlo_next = {numlo_reg[LEVEL_W-2:0], 1'b0};
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_accept)
                begin
                    if (last_word)
                    begin
                        count_next = '0;
                        min_next   = '1;
                        max_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg <= range_next;
        rem_reg   <= rem_next;
        numlo_reg <= numlo_next;
        quot_reg  <= quot_next;
    end

`ifndef NO_ASSERTIONS
    // store never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    // final word taken clears the set
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && m_axis_tlast) |=> (count_reg == '0 && min_reg == '1 && max_reg == '0))
        else $error("set not cleared after final word");

    // partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < range_reg))
        else $error("divider remainder out of range");

    // emission only with a non-empty set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (count_reg != '0))
        else $error("result word with empty set");
`endif

endmodule

// ===== sim/mmn12_level_checker.sv =====
// Checker for the min-max normaliser: rebuilds each data set and compares every emitted level.
`timescale 1ns / 1ps

module mmn12_level_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [mmn12_pkg::SAMPLE_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mmn12_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                              m_tlast,
    output int                                fail_count,
    output int                                pending,
    output int                                levels_checked,
    output int                                sets_closed,
    output int                                full_sets,
    output int                                flat_sets
);

    localparam int LEVEL_W = mmn12_pkg::LEVEL_W;
    localparam int DEPTH   = mmn12_pkg::MAX_SAMPLES;
    localparam logic [63:0] FULL_SCALE = 64'((1 << LEVEL_W) - 1);

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               last;
    } level_word_t;

    level_word_t expected_levels[$];

    logic [mmn12_pkg::SAMPLE_W-1:0] held_samples [DEPTH];
    logic [mmn12_pkg::SAMPLE_W-1:0] set_min;
    logic [mmn12_pkg::SAMPLE_W-1:0] set_max;
    int held_count  = 0;
    int mismatches  = 0;
    int checked_n   = 0;
    int closed_n    = 0;
    int full_n      = 0;
    int flat_n      = 0;

    // floor((x - lo) * 4095 / (hi - lo)); a flat set gives zero
    function automatic logic [LEVEL_W-1:0] stretch_level(input logic [31:0] x,
                                                         input logic [31:0] lo,
                                                         input logic [31:0] hi);
        logic [63:0] span;
        logic [63:0] scaled;
        logic [63:0] quot;
        if (hi <= lo || x < lo)
            return '0;
        span   = 64'(hi) - 64'(lo);
        scaled = (64'(x) - 64'(lo)) * FULL_SCALE;
        quot   = scaled / span;
        if (quot > FULL_SCALE)
            quot = FULL_SCALE;
        return quot[LEVEL_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        level_word_t want;
        if (!rst_n)
        begin
            held_count = 0;
            set_min    = '1;
            set_max    = '0;
            expected_levels.delete();
        end
        else
        begin
            // result side first: a word leaving now belongs to a set already closed
            if (m_tvalid && m_tready)
            begin
                checked_n++;
                if (expected_levels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected level word: expected none, actual level %0d last %0b",
                             $time, m_tdata[LEVEL_W-1:0], m_tlast);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (m_tdata[LEVEL_W-1:0] !== want.level)
                    begin
                        mismatches++;
                        $display("%0t: level mismatch: expected %0d, actual %0d",
                                 $time, want.level, m_tdata[LEVEL_W-1:0]);
                    end
                    if (m_tdata[mmn12_pkg::OUT_DATA_W-1:LEVEL_W] !== '0)
                    begin
                        mismatches++;
                        $display("%0t: padding mismatch: expected 0, actual %0h",
                                 $time, m_tdata[mmn12_pkg::OUT_DATA_W-1:LEVEL_W]);
                    end
                    if (m_tlast !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: last_out mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                held_samples[held_count] = s_tdata;
                held_count++;
                if (s_tdata < set_min)
                    set_min = s_tdata;
                if (s_tdata > set_max)
                    set_max = s_tdata;
                // a full store closes the set whatever tlast says
                if (s_tlast || held_count == DEPTH)
                begin
                    if (held_count == DEPTH)
                        full_n++;
                    if (set_max == set_min)
                        flat_n++;
                    for (int i = 0; i < held_count; i++)
                    begin
                        want.level = stretch_level(held_samples[i], set_min, set_max);
                        want.last  = (i == held_count - 1);
                        expected_levels.push_back(want);
                    end
                    closed_n++;
                    held_count = 0;
                    set_min    = '1;
                    set_max    = '0;
                end
            end
        end
        fail_count     <= mismatches;
        pending        <= expected_levels.size();
        levels_checked <= checked_n;
        sets_closed    <= closed_n;
        full_sets      <= full_n;
        flat_sets      <= flat_n;
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the min-max normaliser: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int TOTAL_WORDS  = 470;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 60;
    localparam int DEPTH        = mmn12_pkg::MAX_SAMPLES;

    typedef enum int {
        SPREAD_WIDE,
        SPREAD_NARROW,
        SPREAD_EDGES,
        SPREAD_FLAT
    } sample_spread_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [mmn12_pkg::SAMPLE_W-1:0]     s_axis_tdata = '0;   // [31:0] sample
    logic                               s_axis_tlast = 1'b0; // last_in
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [mmn12_pkg::OUT_DATA_W-1:0]   m_axis_tdata;        // [11:0] level, [15:12] zero
    logic                               m_axis_tlast;        // last_out

    int fail_count;
    int pending;
    int levels_checked;
    int sets_closed;
    int full_sets;
    int flat_sets;

    int  cycle_count = 0;
    int  words_sent  = 0;
    bit  steady_run  = 1'b0;
    int  ready_hold  = 0;
    int  ready_roll;

    always #5 clk = ~clk;

    min_max_normalize_12bit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mmn12_level_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tlast        (s_axis_tlast),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tlast        (m_axis_tlast),
        .fail_count     (fail_count),
        .pending        (pending),
        .levels_checked (levels_checked),
        .sets_closed    (sets_closed),
        .full_sets      (full_sets),
        .flat_sets      (flat_sets)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stalls: mostly short, a few long, with long stall-free runs too
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 55)
            begin
                m_axis_tready <= 1'b1;
                ready_hold    <= $urandom_range(0, 6);
            end
            else if (ready_roll < 67)
            begin
                m_axis_tready <= 1'b1;
                ready_hold    <= $urandom_range(30, 150);
            end
            else if (ready_roll < 94)
            begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(0, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(10, 40);
            end
        end
    end

    function automatic logic [31:0] pick_sample(input sample_spread_t spread,
                                                input logic [31:0] anchor);
        case (spread)
            SPREAD_WIDE:   return $urandom;
            SPREAD_NARROW: return anchor + $urandom_range(0, 15);
            SPREAD_EDGES:
                case ($urandom_range(0, 4))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h8000_0000;
                    3:       return 32'h7FFF_FFFF;
                    default: return $urandom;
                endcase
            default:       return anchor;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] value, input logic mark_last);
        int gap;
        int roll;
        s_axis_tdata  <= value;
        s_axis_tlast  <= mark_last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        roll = $urandom_range(0, 99);
        if (steady_run || roll < 55)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every level of the closed sets has been taken
    task automatic wait_for_levels();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // {last_in, sample}: single-sample sets, full span, mixed edges, span of one, flat set
    logic [32:0] opening_words [18] = '{
        {1'b1, 32'h0000_0000},
        {1'b1, 32'hFFFF_FFFF},
        {1'b0, 32'h0000_0000}, {1'b1, 32'hFFFF_FFFF},
        {1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h0000_0000}, {1'b0, 32'h8000_0000},
        {1'b0, 32'h7FFF_FFFF}, {1'b0, 32'h0000_0001}, {1'b1, 32'hFFFF_FFFE},
        {1'b0, 32'h0000_0007}, {1'b0, 32'h0000_0008}, {1'b1, 32'h0000_0007},
        {1'b0, 32'h0000_0005}, {1'b0, 32'h0000_0005}, {1'b1, 32'h0000_0005},
        {1'b0, 32'hAAAA_AAAA}, {1'b1, 32'h5555_5555}
    };

    initial
    begin
        int             set_no;
        int             set_len;
        int             roll;
        logic [31:0]    anchor;
        sample_spread_t spread;
        logic           close_bit;

        set_no = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_words[k])
            send_word(opening_words[k][31:0], opening_words[k][32]);
        wait_for_levels();

        while (words_sent < TOTAL_WORDS)
        begin
            roll = $urandom_range(0, 99);
            // first random set always fills the store
            if (set_no == 0 || roll < 10)
                set_len = DEPTH;
            else if (roll < 30)
                set_len = $urandom_range(7, DEPTH - 1);
            else
                set_len = $urandom_range(1, 6);
            // final set trimmed to the word budget
            if (set_len > TOTAL_WORDS - words_sent)
                set_len = TOTAL_WORDS - words_sent;
            spread     = sample_spread_t'($urandom_range(0, 3));
            anchor     = $urandom;
            steady_run = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_len; k++)
            begin
                if (k != set_len - 1)
                    close_bit = 1'b0;
                else if (set_len == DEPTH)
                    close_bit = 1'($urandom_range(0, 1));
                else
                    close_bit = 1'b1;
                send_word(pick_sample(spread, anchor), close_bit);
            end
            set_no++;
            if ($urandom_range(0, 7) == 0)
                wait_for_levels();
        end

        wait_for_levels();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d sample words; %0d sets closed, %0d by a full store, %0d flat.",
                 words_sent, sets_closed, full_sets, flat_sets);
        $display("Checked %0d level words against the predicted contrast stretch.",
                 levels_checked);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mmn12_pkg.sv
hdl/min_max_normalize_12bit.sv
sim/mmn12_level_checker.sv
sim/tb_top.sv
